>>> hw/rtl/pbt_pkg.sv
// ----------------------------------------------------------------------------
// Paged block table package
// Field widths, command and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pbt_pkg;

   localparam int CMD_W      = 2;
   localparam int ID_W       = 16;
   localparam int POS_W      = 16;
   localparam int SLOT_W     = 18;
   localparam int STAT_W     = 3;
   localparam int ENTRIES_W  = 9;
   localparam int BS_CFG_W   = 9;
   localparam int NB_CFG_W   = 11;
   localparam int MC_CFG_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // The divider retires one quotient bit per cycle.
   localparam int DIV_STEPS  = POS_W;
   localparam int STEP_W     = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND    = 2'd0,
      CMD_TRANSLATE = 2'd1,
      CMD_CLEAR     = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 3'd0,
      ST_BAD_ID  = 3'd1,
      ST_MAPPED  = 3'd2,
      ST_CONTEXT = 3'd3,
      ST_SHORT   = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SIZE  = 2'd0,
      CSR_NUM_BLOCKS  = 2'd1,
      CSR_MAX_CONTEXT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic capture;    // take the request fields and preset the divider
      logic map_rd;     // read the used map at the block id
      logic link_rd;    // read the table at the index the map returned
      logic div_step;   // one restoring division step
      logic look_rd;    // read the table at the quotient
      logic mul;        // register table entry times block size
      logic finish;     // commit state and load the response register
   } ctrl_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/paged_block_table_translate.sv
// An append reads the used map and then the table before its result, a clear
// or unknown command goes straight to its result, and a translate runs 16
// divider steps, a table read and the multiply first. The next request is taken
// the cycle after the result is registered, never while one is in progress.
// Reset is synchronous and active high; it empties the table at once and
// restores the register defaults, with no clearing pass.
// ----------------------------------------------------------------------------
// Paged block table translator
// Holds one sequence's block table and turns token positions into cache slots.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_block_table_translate
   import pbt_pkg::*;
#(
   parameter int TABLE_DEPTH    = 256,
   parameter int MAX_BLOCKS     = 1024,
   parameter int MAX_BLOCK_SIZE = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] block id, [31:16] position
   input  wire logic [CMD_W-1:0]      req_tuser,   // [1:0] command
   input  wire logic                  req_tlast,   // last_of_range
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [17:0] slot, [20:18] status,
                                                   // [29:21] entries, [31:30] zero
   output logic                       rsp_tlast,   // last
   // Register write port.
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // The controller walks each transaction through its states and the
   // datapath does the work on command. Appends look up the used map and the
   // table to detect a duplicate id; translates run the divider, read the
   // table at the quotient, multiply by the block size and add the remainder.
   ctrl_cmd_type         cmd;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [STAT_W-1:0]    rsp_status;
   logic [ENTRIES_W-1:0] rsp_entries;

   pbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   pbt_dpath #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .MAX_BLOCKS     (MAX_BLOCKS),
      .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_cmd      (req_tuser),
      .req_blk_id   (req_tdata[ID_W-1:0]),
      .req_position (req_tdata[ID_W+POS_W-1:ID_W]),
      .req_last     (req_tlast),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_slot     (rsp_slot),
      .rsp_status   (rsp_status),
      .rsp_entries  (rsp_entries),
      .rsp_last     (rsp_tlast)
   );

   // The response register sits in the datapath; it only changes when the
   // controller finishes a transaction into a free output.
   assign rsp_tdata = {2'b00, rsp_entries, rsp_status, rsp_slot};

endmodule

`default_nettype wire

>>> hw/rtl/pbt_ctrl.sv
// ----------------------------------------------------------------------------
// Paged block table controller
// Sequences append, translate and clear transactions and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pbt_ctrl
   import pbt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [CMD_W-1:0]   req_tuser,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output ctrl_cmd_type            cmd
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MAP  = 7'b0000010,
      S_LINK = 7'b0000100,
      S_DIV  = 7'b0001000,
      S_LOOK = 7'b0010000,
      S_MUL  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               step_in     = '0;
               case (req_tuser)
                  CMD_APPEND:    state_in = S_MAP;
                  CMD_TRANSLATE: state_in = S_DIV;
                  default:       state_in = S_DONE;
               endcase
            end
         end
         S_MAP: begin
            cmd.map_rd = 1'b1;
            state_in   = S_LINK;
         end
         S_LINK: begin
            cmd.link_rd = 1'b1;
            state_in    = S_DONE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look_rd = 1'b1;
            state_in    = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/pbt_dpath.sv
// ----------------------------------------------------------------------------
// Paged block table datapath
// Registers, table and map memories, divider, multiplier and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module pbt_dpath
   import pbt_pkg::*;
#(
   parameter int TABLE_DEPTH    = 256,
   parameter int MAX_BLOCKS     = 1024,
   parameter int MAX_BLOCK_SIZE = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   input  wire logic [CMD_W-1:0]      req_cmd,
   input  wire logic [ID_W-1:0]       req_blk_id,
   input  wire logic [POS_W-1:0]      req_position,
   input  wire logic                  req_last,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [SLOT_W-1:0]          rsp_slot,
   output logic [STAT_W-1:0]          rsp_status,
   output logic [ENTRIES_W-1:0]       rsp_entries,
   output logic                       rsp_last
);

   localparam int TW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int IDW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int BSW   = $clog2(MAX_BLOCK_SIZE + 1);
   localparam int PRODW = IDW + BSW;
   localparam int SUMW  = PRODW + 1;

   // Configuration registers.
   logic [BS_CFG_W-1:0] bs_ff;
   logic [NB_CFG_W-1:0] nb_ff;
   logic [MC_CFG_W-1:0] mc_ff;

   // Captured request.
   cmd_type           cmd_ff;
   logic [ID_W-1:0]   id_ff;
   logic [POS_W-1:0]  pos_ff;
   logic              last_ff;

   // Table state. The map holds, for each block id, the table index where it
   // was last placed; an id counts as mapped only if that index is below the
   // fill count and the table entry there points back at the id, so neither
   // memory needs clearing.
   logic [IDW-1:0]    table_mem [TABLE_DEPTH];
   logic [TW-1:0]     map_mem   [MAX_BLOCKS];
   logic [IDW-1:0]    tbl_q_ff;
   logic [TW-1:0]     map_q_ff;
   logic [CW-1:0]     count_ff, count_in;

   // Divider and multiplier.
   logic [BSW-1:0]    bs_eff;
   logic [BSW-1:0]    rem_ff, rem_in;
   logic [POS_W-1:0]  quo_ff, quo_in;
   logic [BSW:0]      trial;
   logic [PRODW-1:0]  prod_ff;
   logic [SUMW-1:0]   sum;

   // Result.
   status_type        status;
   logic [SLOT_W-1:0] slot;
   logic              last;
   logic              append_ok;
   logic              id_ok;
   logic              mapped;
   logic              full;
   logic              ctx_bad;
   logic              short;
   logic              pid_bad;
   logic [TW-1:0]     tbl_raddr;

   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [STAT_W-1:0]    rsp_status_ff;
   logic [ENTRIES_W-1:0] rsp_entries_ff;
   logic                 rsp_last_ff;

   always_comb begin
      if (bs_ff == '0) begin
         bs_eff = BSW'(1);
      end else if (32'(bs_ff) > MAX_BLOCK_SIZE) begin
         bs_eff = BSW'(MAX_BLOCK_SIZE);
      end else begin
         bs_eff = BSW'(bs_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff <= BS_CFG_W'(16);
         nb_ff <= NB_CFG_W'(1024);
         mc_ff <= MC_CFG_W'(65536);
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_SIZE:  bs_ff <= csr_wdata[BS_CFG_W-1:0];
            CSR_NUM_BLOCKS:  nb_ff <= csr_wdata[NB_CFG_W-1:0];
            CSR_MAX_CONTEXT: mc_ff <= csr_wdata[MC_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= cmd_type'(req_cmd);
         id_ff   <= req_blk_id;
         pos_ff  <= req_position;
         last_ff <= req_last;
      end
   end

   // Restoring division, one quotient bit per step, dividend shifted out of
   // the quotient register from the top.
   assign trial = {rem_ff, quo_ff[POS_W-1]};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.capture) begin
         rem_in = '0;
         quo_in = req_position;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, bs_eff}) begin
            rem_in = BSW'(trial - {1'b0, bs_eff});
            quo_in = {quo_ff[POS_W-2:0], 1'b1};
         end else begin
            rem_in = trial[BSW-1:0];
            quo_in = {quo_ff[POS_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign tbl_raddr = cmd.link_rd ? map_q_ff : quo_ff[TW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.finish && append_ok) begin
         table_mem[count_ff[TW-1:0]] <= id_ff[IDW-1:0];
      end
      if (cmd.link_rd || cmd.look_rd) begin
         tbl_q_ff <= table_mem[tbl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && append_ok) begin
         map_mem[id_ff[IDW-1:0]] <= count_ff[TW-1:0];
      end
      if (cmd.map_rd) begin
         map_q_ff <= map_mem[id_ff[IDW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= PRODW'(tbl_q_ff) * PRODW'(bs_eff);
      end
   end

   assign sum     = SUMW'(prod_ff) + SUMW'(rem_ff);
   assign id_ok   = (17'(id_ff) < 17'(nb_ff)) && (17'(id_ff) < 17'(MAX_BLOCKS));
   assign mapped  = (CW'(map_q_ff) < count_ff) && (tbl_q_ff == id_ff[IDW-1:0]);
   assign full    = (count_ff >= CW'(TABLE_DEPTH));
   assign ctx_bad = ({1'b0, pos_ff} >= mc_ff);
   assign short   = (17'(quo_ff) >= 17'(count_ff));
   assign pid_bad = (17'(tbl_q_ff) >= 17'(nb_ff));

   always_comb begin
      status    = ST_OK;
      slot      = '0;
      last      = 1'b0;
      append_ok = 1'b0;
      count_in  = count_ff;
      case (cmd_ff)
         CMD_APPEND: begin
            if (!id_ok) begin
               status = ST_BAD_ID;
            end else if (mapped) begin
               status = ST_MAPPED;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               append_ok = 1'b1;
               count_in  = count_ff + CW'(1);
            end
         end
         CMD_TRANSLATE: begin
            last = last_ff;
            if (ctx_bad) begin
               status = ST_CONTEXT;
            end else if (short) begin
               status = ST_SHORT;
            end else if (pid_bad) begin
               status = ST_BAD_ID;
            end else begin
               slot = SLOT_W'(sum);
            end
         end
         CMD_CLEAR: count_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_slot_ff    <= slot;
         rsp_status_ff  <= status;
         rsp_entries_ff <= ENTRIES_W'(count_in);
         rsp_last_ff    <= last;
      end
   end

   assign rsp_slot    = rsp_slot_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_entries = rsp_entries_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/pbt_checker.sv
// ----------------------------------------------------------------------------
// Paged block table checker
// Port-level properties of the translator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbt_checker
   import pbt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  rsp_tlast
);

   // No response may be pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // A flagged result never carries a slot.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[20:18] != ST_OK) |-> (rsp_tdata[17:0] == '0))
      else $error("flagged result with nonzero slot");

   // The controller leaves idle when it takes a request, so a request is never taken in
   // the cycle right after another one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on back-to-back cycles");

   // Status stays within the defined codes and the pad bits stay zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[20:18] <= ST_FULL) && (rsp_tdata[31:30] == 2'b00))
      else $error("response status or padding out of range");

endmodule

bind paged_block_table_translate pbt_checker u_pbt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
